// File: rtl/dtwd_pkg.sv
// Shared types and constants for the dynamic time warping distance block.
// Used by the top level and the cell unit.
// No dependencies.
package dtwd_pkg;

  // Field widths of the item and result payloads
  localparam int ElemW    = 16;
  localparam int CostW    = 24;
  localparam int CfgDataW = 7;
  localparam int CfgIdxW  = 1;

  // Saturation ceiling of the accumulated cost
  localparam logic [CostW-1:0] CostMax = {CostW{1'b1}};

  // Matrix size defaults and the count registers' value after reset
  localparam int DefaultMaxRows = 64;
  localparam int DefaultMaxCols = 64;
  localparam int CountReset     = 64;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] RegRowCount    = 1'b0;
  localparam logic [CfgIdxW-1:0] RegColumnCount = 1'b1;

  // Operands of one recurrence cell
  typedef struct packed {
    logic [ElemW-1:0] elem;
    logic [CostW-1:0] up;
    logic [CostW-1:0] left;
    logic [CostW-1:0] diag;
  } cell_ops_t;

endpackage

// File: rtl/dtwd_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module dtwd_ram #(
  parameter int Width = 16,
  parameter int Depth = 64,
  parameter int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write and read ports
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/dtwd_cell_unit.sv
// Shared recurrence cell: element plus the minimum of up, left and diagonal,
// saturated to the cost width. Depends on dtwd_pkg.
module dtwd_cell_unit (
  input  dtwd_pkg::cell_ops_t             ops_i,
  output logic [dtwd_pkg::CostW-1:0]      sum_o
);

  logic [dtwd_pkg::CostW-1:0] min_ul;
  logic [dtwd_pkg::CostW-1:0] min_all;
  logic [dtwd_pkg::CostW:0]   sum_full;

  // Pick the cheapest predecessor
  assign min_ul  = (ops_i.up < ops_i.left) ? ops_i.up : ops_i.left;
  assign min_all = (min_ul < ops_i.diag) ? min_ul : ops_i.diag;

  // Add the element and clip at the ceiling
  assign sum_full = {1'b0, min_all}
                  + {{(dtwd_pkg::CostW + 1 - dtwd_pkg::ElemW){1'b0}}, ops_i.elem};
  assign sum_o    = sum_full[dtwd_pkg::CostW] ? dtwd_pkg::CostMax
                                              : sum_full[dtwd_pkg::CostW-1:0];

endmodule

// File: rtl/dynamic_time_warping_distance_top.sv
// Top level of the dynamic time warping distance block: load sequencer,
// matrix and cost-row memories, and the shared cell unit.
// Depends on dtwd_pkg, dtwd_ram and dtwd_cell_unit.

// Elements are loaded one per cycle (start_i high while busy_o is low), in
// column-major order with the row index running fastest; busy_o stays low
// throughout the load. With the last element of a row_count x column_count
// matrix the block raises busy_o and walks the recurrence over every cell,
// each cell taking a read state (the matrix and cost-row memories) and then
// a compute state (the shared cell unit, with the write-back). The cost then
// appears on warp_distance_o for one cycle with warp_valid_o high; the
// receiver cannot hold it off, and the block is ready for the next matrix in
// that same cycle. Counts of zero read as one, counts above the maximum
// saturate. Configuration writes are taken while busy_o and start_i are both
// low, and abandon any partial load. No memory clearing is needed after
// reset.
module dynamic_time_warping_distance_top #(
  parameter int MaxRows = dtwd_pkg::DefaultMaxRows,
  parameter int MaxCols = dtwd_pkg::DefaultMaxCols
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  output logic                            busy_o,
  input  logic [dtwd_pkg::ElemW-1:0]      dissimilarity_i,
  output logic                            warp_valid_o,
  output logic [dtwd_pkg::CostW-1:0]      warp_distance_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [dtwd_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [dtwd_pkg::CfgDataW-1:0]   cfg_data_i
);

  localparam int StoreDepth = MaxRows * MaxCols;
  localparam int StoreAw    = (StoreDepth > 1) ? $clog2(StoreDepth) : 1;
  localparam int CntW       = $clog2(StoreDepth + 1);
  localparam int RowW       = $clog2(MaxRows + 1);
  localparam int ColW       = $clog2(MaxCols + 1);
  localparam int RowIdxW    = (MaxRows > 1) ? $clog2(MaxRows) : 1;
  localparam int ColIdxW    = (MaxCols > 1) ? $clog2(MaxCols) : 1;
  localparam int RowsReset  = (dtwd_pkg::CountReset > MaxRows) ? MaxRows
                                                               : dtwd_pkg::CountReset;
  localparam int ColsReset  = (dtwd_pkg::CountReset > MaxCols) ? MaxCols
                                                               : dtwd_pkg::CountReset;

  typedef enum logic [2:0] {
    StLoad = 3'b001,
    StRead = 3'b010,
    StCalc = 3'b100
  } state_e;

  state_e state_q, state_d;

  logic [RowW-1:0]                rows_q, rows_d;
  logic [ColW-1:0]                cols_q, cols_d;
  logic [CntW-1:0]                count_q, count_d;
  logic [dtwd_pkg::ElemW-1:0]     largest_q, largest_d;
  logic [RowIdxW-1:0]             row_q, row_d;
  logic [ColIdxW-1:0]             col_q, col_d;
  logic [StoreAw-1:0]             addr_q, addr_d;
  logic [dtwd_pkg::CostW-1:0]     up_q, up_d;
  logic [dtwd_pkg::CostW-1:0]     diag_q, diag_d;
  logic [dtwd_pkg::CostW-1:0]     result_q, result_d;
  logic                           valid_q, valid_d;

  logic                           cfg_fire;
  logic                           load_fire;
  logic [RowW+ColW-1:0]           total_full;
  logic [CntW-1:0]                total;
  logic [CntW-1:0]                count_inc;
  logic [dtwd_pkg::ElemW-1:0]     elem_max;
  logic [dtwd_pkg::ElemW-1:0]     store_rdata;
  logic [dtwd_pkg::CostW-1:0]     buf_rdata;
  logic [dtwd_pkg::CostW-1:0]     cell_sum;
  logic                           first_row;
  logic                           first_col;
  logic                           last_row;
  logic                           last_col;
  logic                           buf_we;
  dtwd_pkg::cell_ops_t            ops;

  // Hold configuration off while busy or while an element transfer is offered
  assign busy_o      = (state_q != StLoad);
  assign cfg_ready_o = (state_q == StLoad) & ~start_i;
  assign cfg_fire    = cfg_valid_i & cfg_ready_o;
  assign load_fire   = start_i & ~busy_o;

  // Matrix size and load progress
  assign total_full = {{ColW{1'b0}}, rows_q} * {{RowW{1'b0}}, cols_q};
  assign total      = CntW'(total_full);
  assign count_inc  = count_q + CntW'(1);
  assign elem_max   = (dissimilarity_i > largest_q) ? dissimilarity_i : largest_q;

  // Walk position within the matrix
  assign first_row = (row_q == '0);
  assign first_col = (col_q == '0);
  assign last_row  = (RowW'(row_q) == rows_q - RowW'(1));
  assign last_col  = (ColW'(col_q) == cols_q - ColW'(1));

  // Boundary cells come from the largest element; the origin is zero
  always_comb begin
    ops.elem = store_rdata;
    ops.up   = first_row ? {{(dtwd_pkg::CostW-dtwd_pkg::ElemW){1'b0}}, largest_q} : up_q;
    ops.left = first_col ? {{(dtwd_pkg::CostW-dtwd_pkg::ElemW){1'b0}}, largest_q}
                         : buf_rdata;
    if (first_row) begin
      ops.diag = first_col ? '0
                           : {{(dtwd_pkg::CostW-dtwd_pkg::ElemW){1'b0}}, largest_q};
    end else begin
      ops.diag = diag_q;
    end
  end

  dtwd_cell_unit u_cell (
    .ops_i (ops),
    .sum_o (cell_sum)
  );

  assign buf_we = (state_q == StCalc);

  dtwd_ram #(
    .Width (dtwd_pkg::ElemW),
    .Depth (StoreDepth),
    .AddrW (StoreAw)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (load_fire),
    .waddr_i (count_q[StoreAw-1:0]),
    .wdata_i (dissimilarity_i),
    .raddr_i (addr_q),
    .rdata_o (store_rdata)
  );

  dtwd_ram #(
    .Width (dtwd_pkg::CostW),
    .Depth (MaxRows),
    .AddrW (RowIdxW)
  ) u_row_buf (
    .clk_i   (clk_i),
    .we_i    (buf_we),
    .waddr_i (row_q),
    .wdata_i (cell_sum),
    .raddr_i (row_q),
    .rdata_o (buf_rdata)
  );

  // Sequencer: load, then read and compute each cell in turn
  always_comb begin
    state_d   = state_q;
    rows_d    = rows_q;
    cols_d    = cols_q;
    count_d   = count_q;
    largest_d = largest_q;
    row_d     = row_q;
    col_d     = col_q;
    addr_d    = addr_q;
    up_d      = up_q;
    diag_d    = diag_q;
    result_d  = result_q;
    valid_d   = 1'b0;

    case (state_q)
      StLoad: begin
        if (cfg_fire) begin
          case (cfg_index_i)
            dtwd_pkg::RegRowCount: begin
              if (cfg_data_i == '0) begin
                rows_d = RowW'(1);
              end else if (int'(cfg_data_i) > MaxRows) begin
                rows_d = RowW'(MaxRows);
              end else begin
                rows_d = RowW'(cfg_data_i);
              end
            end
            dtwd_pkg::RegColumnCount: begin
              if (cfg_data_i == '0) begin
                cols_d = ColW'(1);
              end else if (int'(cfg_data_i) > MaxCols) begin
                cols_d = ColW'(MaxCols);
              end else begin
                cols_d = ColW'(cfg_data_i);
              end
            end
            default: begin
              rows_d = rows_q;
            end
          endcase
          count_d   = '0;
          largest_d = '0;
        end else if (load_fire) begin
          largest_d = elem_max;
          if (count_inc == total) begin
            count_d = '0;
            row_d   = '0;
            col_d   = '0;
            addr_d  = '0;
            state_d = StRead;
          end else begin
            count_d = count_inc;
          end
        end
      end
      StRead: begin
        state_d = StCalc;
      end
      StCalc: begin
        up_d   = cell_sum;
        diag_d = ops.left;
        if (last_row && last_col) begin
          result_d  = cell_sum;
          valid_d   = 1'b1;
          largest_d = '0;
          state_d   = StLoad;
        end else begin
          addr_d  = addr_q + StoreAw'(1);
          state_d = StRead;
          if (last_row) begin
            row_d = '0;
            col_d = col_q + ColIdxW'(1);
          end else begin
            row_d = row_q + RowIdxW'(1);
          end
        end
      end
      default: begin
        state_d = StLoad;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StLoad;
      rows_q    <= RowW'(RowsReset);
      cols_q    <= ColW'(ColsReset);
      count_q   <= '0;
      largest_q <= '0;
      row_q     <= '0;
      col_q     <= '0;
      addr_q    <= '0;
      valid_q   <= 1'b0;
    end else begin
      state_q   <= state_d;
      rows_q    <= rows_d;
      cols_q    <= cols_d;
      count_q   <= count_d;
      largest_q <= largest_d;
      row_q     <= row_d;
      col_q     <= col_d;
      addr_q    <= addr_d;
      valid_q   <= valid_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    up_q     <= up_d;
    diag_q   <= diag_d;
    result_q <= result_d;
  end

  assign warp_valid_o    = valid_q;
  assign warp_distance_o = result_q;

endmodule

// File: rtl/dtwd_checker.sv
// Port-level checker for the dynamic time warping distance top level,
// attached by the bind below. No package dependencies.
module dtwd_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            start_i,
  input logic                            busy_o,
  input logic                            warp_valid_o,
  input logic                            cfg_ready_o
);

  // A result marks the end of a computation
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    warp_valid_o |-> !busy_o)
    else $error("result shown while still busy");

  // Busy drops only with a result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy_o) |-> warp_valid_o)
    else $error("busy dropped without a result");

  // Busy rises only after an accepted transfer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy_o) |-> $past(start_i))
    else $error("busy rose without a start");

  // Configuration is taken only when idle and no element is offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_ready_o == (!busy_o && !start_i))
    else $error("configuration ready disagrees with busy and start");

  // One strobe per result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    warp_valid_o |=> !warp_valid_o)
    else $error("result strobe longer than one cycle");

endmodule

bind dynamic_time_warping_distance_top dtwd_checker u_dtwd_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .start_i         (start_i),
  .busy_o          (busy_o),
  .warp_valid_o    (warp_valid_o),
  .cfg_ready_o     (cfg_ready_o)
);
